>>> hw/rtl/tmt_pkg.sv
// Shared types and constants of the temperature monitor trip block.
// No dependencies; every other file imports this package.
package tmt_pkg;

    localparam int LIMIT_BITS  = 15;
    localparam int TRIP_BITS   = 4;
    localparam int RUN_BITS    = 4;
    localparam int SUM_BITS    = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 3;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 15'd1280;
    localparam logic [TRIP_BITS-1:0]  TRIP_RESET  = 4'd3;
    localparam logic [RUN_BITS-1:0]   RUN_MAX     = 4'd15;
    localparam logic [SUM_BITS-1:0]   SUM_MAX     = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic [SUM_BITS-1:0]   SUM_MIN     = {1'b1, {(SUM_BITS-1){1'b0}}};

    // register index, taken from paddr bit 2
    localparam logic REG_TEMP_LIMIT = 1'b0;
    localparam logic REG_TRIP_COUNT = 1'b1;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] temp_limit;
        logic [TRIP_BITS-1:0]  trip_count;
    } t_cfg;

    typedef struct packed {
        logic over_limit;
        logic shutdown;
        logic session_end;
    } t_flags;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_state;

endpackage

>>> hw/rtl/tmt_front.sv
// Front end: takes samples, tags the session-ending zero sample and
// holds them in a two-entry queue for the back end. Uses tmt_pkg.
module tmt_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_item_valid,
    output logic [SAMPLE_BITS-1:0] o_item_sample,
    output logic                   o_item_zero,
    input  logic                   i_item_take
);
    import tmt_pkg::*;

    localparam int PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(QUEUE_DEPTH);

    logic [SAMPLE_BITS-1:0] r_slot_sample [QUEUE_DEPTH];
    logic                   r_slot_zero   [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]    r_wr_ptr;
    logic [PTR_BITS-1:0]    r_rd_ptr;
    logic [FILL_BITS-1:0]   r_fill;
    logic                   wr_en;
    logic                   rd_en;

    assign o_full        = (r_fill == FILL_FULL);
    assign o_item_valid  = (r_fill != '0);
    assign o_item_sample = r_slot_sample[r_rd_ptr];
    assign o_item_zero   = r_slot_zero[r_rd_ptr];
    assign wr_en         = i_push && !o_full;
    assign rd_en         = i_item_take && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_sample[r_wr_ptr] <= i_sample;
            r_slot_zero[r_wr_ptr]   <= (i_sample == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_fill <= r_fill + FILL_BITS'(wr_en) - FILL_BITS'(rd_en);
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("front queue fill beyond depth");
`endif

endmodule

>>> hw/rtl/tmt_div.sv
// Iterative signed-by-unsigned divider for the session mean, one quotient
// bit per cycle, truncating toward zero. Uses tmt_pkg.
module tmt_div #(
    parameter int COUNT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tmt_pkg::SUM_BITS-1:0]   i_dividend,
    input  logic [COUNT_BITS-1:0]          i_divisor,
    output logic                           o_done,
    output logic [tmt_pkg::SUM_BITS-1:0]   o_quotient
);
    import tmt_pkg::*;

    localparam int STEP_BITS = $clog2(SUM_BITS);
    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(SUM_BITS - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_BITS-1:0]  r_step;
    logic                  r_neg;
    logic [SUM_BITS-1:0]   r_quo;
    logic [COUNT_BITS:0]   r_rem;
    logic [COUNT_BITS-1:0] r_den;
    logic [COUNT_BITS:0]   shifted;
    logic                  fits;

    assign shifted    = {r_rem[COUNT_BITS-1:0], r_quo[SUM_BITS-1]};
    assign fits       = (shifted >= {1'b0, r_den});
    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_BITS-1];
            r_quo <= i_dividend[SUM_BITS-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (shifted - {1'b0, r_den}) : shifted;
            r_quo <= {r_quo[SUM_BITS-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy && !r_done)
        else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a run");
`endif

endmodule

>>> hw/rtl/tmt_back.sv
// Back end: updates session statistics per sample, runs the mean division
// at session end and holds the result for transfer. Uses tmt_pkg, tmt_div.
module tmt_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tmt_pkg::t_cfg                       i_cfg,
    input  logic                                i_item_valid,
    input  logic [SAMPLE_BITS-1:0]              i_item_sample,
    input  logic                                i_item_zero,
    output logic                                o_item_take,
    output logic                                o_div_start,
    output logic [tmt_pkg::SUM_BITS-1:0]        o_div_dividend,
    output logic [COUNT_BITS-1:0]               o_div_divisor,
    input  logic                                i_div_done,
    input  logic [tmt_pkg::SUM_BITS-1:0]        i_div_quotient,
    input  logic                                i_pop,
    output logic                                o_empty,
    output tmt_pkg::t_flags                     o_flags,
    output logic [tmt_pkg::RUN_BITS-1:0]        o_run_length,
    output logic [COUNT_BITS-1:0]               o_reading_count,
    output logic [COUNT_BITS-1:0]               o_above_count,
    output logic [SAMPLE_BITS-1:0]              o_max_temp,
    output logic [SAMPLE_BITS-1:0]              o_min_temp,
    output logic [SAMPLE_BITS-1:0]              o_mean_temp
);
    import tmt_pkg::*;

    localparam int CMP_BITS = ((SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS) + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    t_state                  r_state;
    t_state                  n_state;

    logic [SUM_BITS-1:0]     r_sum;
    logic [COUNT_BITS-1:0]   r_count;
    logic [COUNT_BITS-1:0]   r_above;
    logic [RUN_BITS-1:0]     r_run;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic signed [SAMPLE_BITS-1:0] r_min;

    logic                    r_out_valid;
    t_flags                  r_res_flags;
    logic [RUN_BITS-1:0]     r_res_run;
    logic [COUNT_BITS-1:0]   r_res_count;
    logic [COUNT_BITS-1:0]   r_res_above;
    logic [SAMPLE_BITS-1:0]  r_res_max;
    logic [SAMPLE_BITS-1:0]  r_res_min;
    logic [SAMPLE_BITS-1:0]  r_res_mean;

    logic signed [SAMPLE_BITS-1:0] s;
    logic signed [CMP_BITS-1:0]    s_cmp;
    logic signed [CMP_BITS-1:0]    limit_cmp;
    logic [SUM_BITS:0]       sum_wide;
    logic                    over;
    logic [SUM_BITS-1:0]     st_sum;
    logic [COUNT_BITS-1:0]   st_count;
    logic [COUNT_BITS-1:0]   st_above;
    logic [RUN_BITS-1:0]     st_run;
    logic signed [SAMPLE_BITS-1:0] st_max;
    logic signed [SAMPLE_BITS-1:0] st_min;
    t_flags                  flags;
    logic                    out_free;
    logic                    take;
    logic                    load;

    assign s         = $signed(i_item_sample);
    assign s_cmp     = $signed({{(CMP_BITS-SAMPLE_BITS){i_item_sample[SAMPLE_BITS-1]}},
                                i_item_sample});
    assign limit_cmp = $signed({{(CMP_BITS-LIMIT_BITS){1'b0}}, i_cfg.temp_limit});
    assign over      = (s_cmp > limit_cmp);
    assign sum_wide  = {r_sum[SUM_BITS-1], r_sum}
                     + {{(SUM_BITS+1-SAMPLE_BITS){i_item_sample[SAMPLE_BITS-1]}},
                        i_item_sample};
    assign out_free  = !r_out_valid || i_pop;

    // statistics after this sample, before any session clear
    always_comb begin
        st_sum   = r_sum;
        st_count = r_count;
        st_above = r_above;
        st_run   = r_run;
        st_max   = r_max;
        st_min   = r_min;
        if (!i_item_zero) begin
            if (r_count == '0) begin
                st_max = s;
                st_min = s;
            end else begin
                if (s > r_max) st_max = s;
                if (s < r_min) st_min = s;
            end
            if (r_count != CNT_MAX) begin
                if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
                    st_sum = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
                end else begin
                    st_sum = sum_wide[SUM_BITS-1:0];
                end
                st_count = r_count + 1'b1;
            end
            if (over) begin
                if (r_above != CNT_MAX) st_above = r_above + 1'b1;
                if (r_run != RUN_MAX)   st_run   = r_run + 1'b1;
            end else begin
                st_run = '0;
            end
        end
        flags.over_limit  = !i_item_zero && over;
        flags.shutdown    = !i_item_zero && (st_run >= i_cfg.trip_count);
        flags.session_end = i_item_zero || flags.shutdown;
    end

    always_comb begin
        n_state     = r_state;
        take        = 1'b0;
        load        = 1'b0;
        o_div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid && out_free) begin
                    take = 1'b1;
                    if (flags.session_end && st_count != '0) begin
                        o_div_start = 1'b1;
                        n_state     = ST_DIV;
                    end else begin
                        load = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (i_div_done) begin
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_item_take    = take;
    assign o_div_dividend = st_sum;
    assign o_div_divisor  = st_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_count     <= '0;
            r_above     <= '0;
            r_run       <= '0;
            r_max       <= '0;
            r_min       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                if (flags.session_end) begin
                    r_sum   <= '0;
                    r_count <= '0;
                    r_above <= '0;
                    r_run   <= '0;
                    r_max   <= '0;
                    r_min   <= '0;
                end else begin
                    r_sum   <= st_sum;
                    r_count <= st_count;
                    r_above <= st_above;
                    r_run   <= st_run;
                    r_max   <= st_max;
                    r_min   <= st_min;
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // capture the result at take; the mean lands when the divider finishes
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res_flags <= flags;
            r_res_run   <= st_run;
            r_res_count <= st_count;
            r_res_above <= st_above;
            r_res_max   <= st_max;
            r_res_min   <= st_min;
            r_res_mean  <= '0;
        end else if (r_state == ST_DIV && i_div_done) begin
            r_res_mean  <= i_div_quotient[SAMPLE_BITS-1:0];
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_flags         = r_res_flags;
    assign o_run_length    = r_res_run;
    assign o_reading_count = r_res_count;
    assign o_above_count   = r_res_above;
    assign o_max_temp      = r_res_max;
    assign o_min_temp      = r_res_min;
    assign o_mean_temp     = r_res_mean;

`ifndef NO_ASSERTIONS
    a_div_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> !r_out_valid)
        else $error("result shown while mean still in progress");
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_done |-> r_state == ST_DIV)
        else $error("divider finished outside the division state");
`endif

endmodule

>>> hw/rtl/temperature_monitor_trip_top.sv
// Top level of the over-temperature monitor: configuration registers and
// the front queue, back end and mean divider. Uses tmt_pkg and all tmt_ modules.
// Usage:
//   Samples enter as a queue: drive i_temp_sample with push high; the sample
//   transfers at a clock edge where full is low. Results leave as a queue: the
//   oldest result is on the o_ ports while empty is low and transfers on an
//   edge with pop high. One result per sample.
//   Flow: a sample is written into the front queue, taken by the back end and
//   registered as a result; a sample that ends a session holding readings
//   first waits for the 32-step bit-per-cycle mean divider. Ordinary samples sustain
//   one per cycle while results are popped; a session end blocks the back end for the division.
//   A two-entry queue sits between front and back, so samples keep
//   transferring while a result waits or the mean is computed; once it fills,
//   full rises and holds until the back end takes a sample again.
//   Registers (APB, pready always high): temp_limit at 0x0, trip_count at
//   0x4. A write of zero to either register is ignored. Write them only when
//   no sample is in flight.
//   Reset (synchronous, active low) restores temp_limit 1280, trip_count 3,
//   clears all session statistics and empties both queues.
module temperature_monitor_trip_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tmt_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [tmt_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [tmt_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    input  logic                                push,
    output logic                                full,
    input  logic [SAMPLE_BITS-1:0]              i_temp_sample,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_over_limit,
    output logic [tmt_pkg::RUN_BITS-1:0]        o_run_length,
    output logic                                o_shutdown,
    output logic                                o_session_end,
    output logic [COUNT_BITS-1:0]               o_reading_count,
    output logic [COUNT_BITS-1:0]               o_above_count,
    output logic [SAMPLE_BITS-1:0]              o_max_temp,
    output logic [SAMPLE_BITS-1:0]              o_min_temp,
    output logic [SAMPLE_BITS-1:0]              o_mean_temp
);
    import tmt_pkg::*;

    t_cfg                   r_cfg;
    logic                   cfg_wr;
    logic                   item_valid;
    logic [SAMPLE_BITS-1:0] item_sample;
    logic                   item_zero;
    logic                   item_take;
    logic                   div_start;
    logic [SUM_BITS-1:0]    div_dividend;
    logic [COUNT_BITS-1:0]  div_divisor;
    logic                   div_done;
    logic [SUM_BITS-1:0]    div_quotient;
    t_flags                 flags;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_limit <= LIMIT_RESET;
            r_cfg.trip_count <= TRIP_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_TEMP_LIMIT: begin
                    if (pwdata[LIMIT_BITS-1:0] != '0) begin
                        r_cfg.temp_limit <= pwdata[LIMIT_BITS-1:0];
                    end
                end
                REG_TRIP_COUNT: begin
                    if (pwdata[TRIP_BITS-1:0] != '0) begin
                        r_cfg.trip_count <= pwdata[TRIP_BITS-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TEMP_LIMIT: prdata = {{(CFG_DATA_BITS-LIMIT_BITS){1'b0}}, r_cfg.temp_limit};
            REG_TRIP_COUNT: prdata = {{(CFG_DATA_BITS-TRIP_BITS){1'b0}}, r_cfg.trip_count};
            default:        prdata = '0;
        endcase
    end

    tmt_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_sample      (i_temp_sample),
        .o_item_valid  (item_valid),
        .o_item_sample (item_sample),
        .o_item_zero   (item_zero),
        .i_item_take   (item_take)
    );

    tmt_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    tmt_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_item_valid    (item_valid),
        .i_item_sample   (item_sample),
        .i_item_zero     (item_zero),
        .o_item_take     (item_take),
        .o_div_start     (div_start),
        .o_div_dividend  (div_dividend),
        .o_div_divisor   (div_divisor),
        .i_div_done      (div_done),
        .i_div_quotient  (div_quotient),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_flags         (flags),
        .o_run_length    (o_run_length),
        .o_reading_count (o_reading_count),
        .o_above_count   (o_above_count),
        .o_max_temp      (o_max_temp),
        .o_min_temp      (o_min_temp),
        .o_mean_temp     (o_mean_temp)
    );

    assign o_over_limit  = flags.over_limit;
    assign o_shutdown    = flags.shutdown;
    assign o_session_end = flags.session_end;

endmodule

>>> verif/tb_top.sv
// Testbench for temperature_monitor_trip_top: pushes Q12.4 samples, writes the
// limit and trip registers over APB and checks every status result against an
// in-bench monitor model. Depends on tmt_pkg and the RTL under hw/rtl.
module tb_top;
    import tmt_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic               over_limit;
        logic [3:0]         run_length;
        logic               shutdown;
        logic               session_end;
        logic [15:0]        reading_count;
        logic [15:0]        above_count;
        logic signed [15:0] max_temp;
        logic signed [15:0] min_temp;
        logic signed [15:0] mean_temp;
    } t_status;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     push = 1'b0;
    logic                     full;
    logic [15:0]              i_temp_sample = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic                     o_over_limit;
    logic [RUN_BITS-1:0]      o_run_length;
    logic                     o_shutdown;
    logic                     o_session_end;
    logic [15:0]              o_reading_count;
    logic [15:0]              o_above_count;
    logic [15:0]              o_max_temp;
    logic [15:0]              o_min_temp;
    logic [15:0]              o_mean_temp;

    // monitor model: configuration and session statistics
    logic [LIMIT_BITS-1:0] cfg_limit = LIMIT_RESET;
    logic [TRIP_BITS-1:0]  cfg_trip = TRIP_RESET;
    int                    sess_sum = 0;
    logic [15:0]           sess_count = '0;
    logic [15:0]           sess_above = '0;
    logic [3:0]            sess_run = '0;
    logic signed [15:0]    sess_max = '0;
    logic signed [15:0]    sess_min = '0;

    t_status status_q[$];
    t_status head_r;
    int      err_count = 0;
    int      send_idle_pct = 13;
    int      recv_idle_pct = 71;
    int      hold_left = 0;
    int      idle_cycles = 0;

    temperature_monitor_trip_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .push           (push),
        .full           (full),
        .i_temp_sample  (i_temp_sample),
        .empty          (empty),
        .pop            (pop),
        .o_over_limit   (o_over_limit),
        .o_run_length   (o_run_length),
        .o_shutdown     (o_shutdown),
        .o_session_end  (o_session_end),
        .o_reading_count(o_reading_count),
        .o_above_count  (o_above_count),
        .o_max_temp     (o_max_temp),
        .o_min_temp     (o_min_temp),
        .o_mean_temp    (o_mean_temp)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Advance the session by one sample and return the status it produces.
    function automatic t_status monitor_step(logic signed [15:0] s);
        t_status r;
        longint  nsum;
        logic    ends;
        ends = 1'b0;
        r.over_limit = 1'b0;
        r.shutdown = 1'b0;
        r.mean_temp = '0;
        if (s == 0) begin
            ends = 1'b1;
        end else begin
            if (sess_count == 0) begin
                sess_max = s;
                sess_min = s;
            end else begin
                if (s > sess_max) sess_max = s;
                if (s < sess_min) sess_min = s;
            end
            // stop accumulating once the count saturates so the mean stays consistent
            if (sess_count != 16'hFFFF) begin
                nsum = longint'(sess_sum) + longint'(s);
                if (nsum > 64'sd2147483647) nsum = 64'sd2147483647;
                if (nsum < -64'sd2147483648) nsum = -64'sd2147483648;
                sess_sum = int'(nsum);
                sess_count++;
            end
            if (int'(s) > int'(cfg_limit)) begin
                r.over_limit = 1'b1;
                if (sess_above != 16'hFFFF) sess_above++;
                if (sess_run != RUN_MAX) sess_run++;
            end else begin
                sess_run = '0;
            end
            if (sess_run >= cfg_trip) begin
                r.shutdown = 1'b1;
                ends = 1'b1;
            end
        end
        if (ends && sess_count != 0) begin
            r.mean_temp = 16'(sess_sum / int'(sess_count));
        end
        r.run_length = sess_run;
        r.session_end = ends;
        r.reading_count = sess_count;
        r.above_count = sess_above;
        r.max_temp = sess_max;
        r.min_temp = sess_min;
        if (ends) begin
            sess_sum = 0;
            sess_count = '0;
            sess_above = '0;
            sess_run = '0;
            sess_max = '0;
            sess_min = '0;
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic signed [31:0] exp_v,
                                        logic signed [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // receiver: random pop, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (status_q.size() == 0) begin
                $display("%0t: result transfer with nothing expected", $time);
                err_count++;
            end else begin
                head_r = status_q.pop_front();
                check_field("over_limit", 32'(head_r.over_limit), 32'(o_over_limit));
                check_field("run_length", 32'(head_r.run_length), 32'(o_run_length));
                check_field("shutdown", 32'(head_r.shutdown), 32'(o_shutdown));
                check_field("session_end", 32'(head_r.session_end), 32'(o_session_end));
                check_field("reading_count", 32'(head_r.reading_count),
                            32'(o_reading_count));
                check_field("above_count", 32'(head_r.above_count), 32'(o_above_count));
                check_field("max_temp", 32'(head_r.max_temp), 32'($signed(o_max_temp)));
                check_field("min_temp", 32'(head_r.min_temp), 32'($signed(o_min_temp)));
                check_field("mean_temp", 32'(head_r.mean_temp), 32'($signed(o_mean_temp)));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_sample(logic signed [15:0] s);
        // keep push low while a draw falls under the sender's idle odds
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_temp_sample <= s;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        status_q.push_back(monitor_step(s));
    endtask

    // Drop push and wait until every expected status has come back.
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        // zero writes leave the register unchanged
        if (idx == REG_TEMP_LIMIT && value[LIMIT_BITS-1:0] != 0) begin
            cfg_limit = value[LIMIT_BITS-1:0];
        end else if (idx == REG_TRIP_COUNT && value[TRIP_BITS-1:0] != 0) begin
            cfg_trip = value[TRIP_BITS-1:0];
        end
    endtask

    task automatic read_check(logic idx);
        logic [31:0] want;
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_TEMP_LIMIT) begin
            want = 32'(cfg_limit);
            got = 32'(prdata[LIMIT_BITS-1:0]);
        end else begin
            want = 32'(cfg_trip);
            got = 32'(prdata[TRIP_BITS-1:0]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        check_field(idx == REG_TEMP_LIMIT ? "temp_limit" : "trip_count", want, got);
    endtask

    task automatic check_regs();
        read_check(REG_TEMP_LIMIT);
        read_check(REG_TRIP_COUNT);
    endtask

    // Mostly samples around the limit, with zeros, extremes and raw noise mixed in.
    function automatic logic signed [15:0] pick_sample();
        int r;
        int v;
        int lim;
        lim = int'(cfg_limit);
        r = $urandom_range(99);
        if (r < 4) begin
            v = 0;
        end else if (r < 14) begin
            v = int'($signed(16'($urandom)));
        end else if (r < 20) begin
            case ($urandom_range(5))
                0: v = -32768;
                1: v = 32767;
                2: v = -1;
                3: v = 1;
                4: v = lim;
                default: v = lim + 1;
            endcase
        end else begin
            v = lim + int'($urandom_range(63)) - 32;
        end
        if (v > 32767) v = 32767;
        return 16'(v);
    endfunction

    task automatic test_reset_values();
        check_regs();
    endtask

    task automatic test_empty_session();
        send_sample(16'sd0);
        drain();
    endtask

    task automatic test_extremes();
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'(cfg_limit));
        send_sample(16'sd0);
        drain();
    endtask

    task automatic test_trip();
        repeat (3) send_sample(16'(int'(cfg_limit) + 1));
        drain();
    endtask

    task automatic test_zero_writes();
        write_reg(REG_TEMP_LIMIT, 32'd0);
        write_reg(REG_TRIP_COUNT, 32'd0);
        check_regs();
    endtask

    // Lower the trip count mid-session so the run is already past it.
    task automatic test_run_beyond_trip();
        write_reg(REG_TEMP_LIMIT, 32'd1);
        write_reg(REG_TRIP_COUNT, 32'd15);
        repeat (5) send_sample(16'($urandom_range(2, 32767)));
        drain();
        write_reg(REG_TRIP_COUNT, 32'd2);
        check_regs();
        send_sample(16'($urandom_range(2, 32767)));
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_TEMP_LIMIT, 32'd1280);
        write_reg(REG_TRIP_COUNT, 32'd3);
        hold_left = 300;
        repeat (40) send_sample(pick_sample());
        drain();
    endtask

    task automatic test_random(int n_items, int snd_pct, int rcv_pct,
                               logic [LIMIT_BITS-1:0] limit, logic [TRIP_BITS-1:0] trip);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        write_reg(REG_TEMP_LIMIT, 32'(limit));
        write_reg(REG_TRIP_COUNT, 32'(trip));
        check_regs();
        repeat (n_items) send_sample(pick_sample());
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_empty_session();
        test_extremes();
        test_trip();
        test_zero_writes();
        test_run_beyond_trip();
        test_backpressure();

        test_random(290, 13, 71, 15'd1, 4'd1);
        test_random(290, 13, 71, 15'd32767, 4'd15);
        test_random(290, 71, 13, 15'($urandom_range(1, 32767)), 4'($urandom_range(1, 15)));
        test_random(290, 71, 13, 15'd1280, 4'd15);
        test_random(290, 0, 0, 15'($urandom_range(1, 4000)), 4'($urandom_range(1, 15)));
        test_random(290, 0, 0, 15'd200, 4'd2);

        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
